// ===== src/cbts_pkg.sv =====
`default_nettype none

package cbts_pkg;

	localparam int unsigned TICKS_PER_SECOND_DEF = 64;

	localparam int unsigned IN_W       = 8;
	localparam int unsigned OUT_W      = 48;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RATE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_RATE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_AFTER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_REPS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 3'd5;

	localparam logic [5:0] SLOW_RATE_RST    = 6'd16;
	localparam logic [5:0] FAST_RATE_RST    = 6'd55;
	localparam logic [7:0] FAST_AFTER_RST   = 8'd5;
	localparam logic [7:0] IDLE_TIMEOUT_RST = 8'd128;
	localparam logic [3:0] BLINK_REPS_RST   = 4'd5;
	localparam logic [5:0] BLINK_HALF_RST   = 6'd4;

	localparam logic [4:0] HOURS_RST   = 5'd9;
	localparam logic [6:0] SEC_MOD     = 7'd60;
	localparam logic [6:0] MIN_MOD     = 7'd60;
	localparam logic [5:0] HOUR_MOD    = 6'd24;

	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_SPACE = 6'd32;

	typedef enum logic [2:0] {
		MODE_CLOCK,
		MODE_HOUR_BLINK,
		MODE_SET_HOURS,
		MODE_MIN_BLINK,
		MODE_SET_MINS,
		MODE_EXIT_BLINK
	} cbts_mode_t;

	typedef struct packed {
		logic [5:0] slow_rate;
		logic [5:0] fast_rate;
		logic [7:0] fast_after;
		logic [7:0] idle_timeout;
		logic [3:0] blink_reps;
		logic [5:0] blink_half;
	} cbts_cfg_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		cbts_mode_t mode;
		logic       blank_h;
		logic       blank_m;
		logic       fade;
	} cbts_view_t;

	function automatic logic [2:0] digit_tens(input logic [5:0] v);
		logic [2:0] t;
		if (v >= 6'd60)      t = 3'd6;
		else if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else                 t = 3'd0;
		return t;
	endfunction

	function automatic logic [3:0] digit_ones(input logic [5:0] v);
		logic [2:0] t;
		logic [5:0] r;
		t = digit_tens(v);
		r = v - {t, 3'b000} - {2'b00, t, 1'b0};
		return r[3:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/cbts_core.sv =====
`default_nettype none

module cbts_core
	import cbts_pkg::*;
#(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       held,
	input  wire logic       pressed,
	input  wire cbts_cfg_t  cfg,
	output cbts_view_t      view
);

	localparam logic [6:0] TPS7 = 7'(TICKS_PER_SECOND);

	logic [4:0] hours_q, hours_d;
	logic [5:0] minutes_q, minutes_d;
	logic [5:0] seconds_q, seconds_d;
	logic [5:0] presc_q, presc_d;
	cbts_mode_t mode_q, mode_d;
	logic [7:0] pt_q, pt_d;
	logic [3:0] blink_q, blink_d;
	logic [5:0] hold_q, hold_d;
	logic [7:0] steps_q, steps_d;
	logic       fast_q, fast_d;

	logic [6:0] pre_inc;
	logic       second_due;
	logic       fade;
	logic       do_enter;
	cbts_mode_t enter_target;
	cbts_mode_t blink_next;
	logic [7:0] pt_inc;
	logic [3:0] bc_inc;
	logic [5:0] rate;
	logic [6:0] target;
	logic       do_bump;
	logic       check_fast;
	logic [5:0] hr_inc;
	logic [6:0] mn_inc;
	logic [6:0] sec_inc;
	logic       min_c;
	logic       hr_c;

	always_comb begin
		hours_d      = hours_q;
		minutes_d    = minutes_q;
		seconds_d    = seconds_q;
		mode_d       = mode_q;
		pt_d         = pt_q;
		blink_d      = blink_q;
		hold_d       = hold_q;
		steps_d      = steps_q;
		fast_d       = fast_q;
		fade         = 1'b0;
		do_enter     = 1'b0;
		enter_target = MODE_CLOCK;
		do_bump      = 1'b0;
		check_fast   = 1'b0;
		pt_inc       = pt_q + 8'd1;
		bc_inc       = blink_q + 4'd1;
		rate         = fast_q ? cfg.fast_rate : cfg.slow_rate;
		target       = ({1'b0, rate} < TPS7) ? (TPS7 - {1'b0, rate}) : 7'd1;
		sec_inc      = {1'b0, seconds_q} + 7'd1;
		min_c        = 1'b0;
		hr_c         = 1'b0;
		mn_inc       = {1'b0, minutes_q};
		hr_inc       = {1'b0, hours_q};

		pre_inc    = {1'b0, presc_q} + 7'd1;
		second_due = (pre_inc >= TPS7) || (pre_inc > 7'd63);
		presc_d    = second_due ? 6'd0 : pre_inc[5:0];

		blink_next = (mode_q == MODE_EXIT_BLINK) ? MODE_CLOCK : cbts_mode_t'(mode_q + 3'd1);

		unique case (mode_q)
			MODE_HOUR_BLINK, MODE_MIN_BLINK, MODE_EXIT_BLINK: begin
				if (blink_q >= cfg.blink_reps) begin
					do_enter     = 1'b1;
					enter_target = blink_next;
				end else begin
					pt_d = pt_inc;
					if (pt_inc >= {1'b0, cfg.blink_half, 1'b0}) begin
						pt_d    = 8'd0;
						blink_d = bc_inc;
						if (bc_inc >= cfg.blink_reps) begin
							do_enter     = 1'b1;
							enter_target = blink_next;
						end
					end
				end
				if (do_enter && enter_target == MODE_CLOCK) begin
					seconds_d = 6'd0;
				end
			end
			MODE_SET_HOURS, MODE_SET_MINS: begin
				if (held) begin
					pt_d = 8'd0;
					if (hold_q == 6'd0) begin
						hold_d  = 6'd1;
						do_bump = 1'b1;
					end else if ({1'b0, hold_q} == target) begin
						hold_d     = 6'd1;
						do_bump    = 1'b1;
						check_fast = 1'b1;
					end else begin
						hold_d = hold_q + 6'd1;
					end
				end else begin
					hold_d  = 6'd0;
					steps_d = 8'd0;
					fast_d  = 1'b0;
					pt_d    = (pt_q == 8'hFF) ? pt_q : pt_inc;
					if (pt_d >= cfg.idle_timeout) begin
						do_enter     = 1'b1;
						enter_target = (mode_q == MODE_SET_HOURS) ? MODE_MIN_BLINK
							: MODE_EXIT_BLINK;
					end
				end
				if (do_bump) begin
					if (mode_q == MODE_SET_HOURS) begin
						hr_inc  = {1'b0, hours_q} + 6'd1;
						hours_d = (hr_inc >= HOUR_MOD) ? 5'd0 : hr_inc[4:0];
					end else begin
						mn_inc    = {1'b0, minutes_q} + 7'd1;
						minutes_d = (mn_inc >= MIN_MOD) ? 6'd0 : mn_inc[5:0];
					end
					steps_d = (steps_q == 8'hFF) ? steps_q : steps_q + 8'd1;
					if (check_fast && steps_d == cfg.fast_after) begin
						fast_d = 1'b1;
					end
				end
			end
			default: begin
				mode_d = MODE_CLOCK;
				if (second_due) begin
					if (sec_inc >= SEC_MOD) begin
						seconds_d = 6'd0;
						min_c     = 1'b1;
						fade      = 1'b1;
					end else begin
						seconds_d = sec_inc[5:0];
					end
					mn_inc = {1'b0, minutes_q} + {6'd0, min_c};
					if (mn_inc >= MIN_MOD) begin
						minutes_d = 6'd0;
						hr_c      = 1'b1;
						fade      = 1'b1;
					end else begin
						minutes_d = mn_inc[5:0];
					end
					hr_inc  = {1'b0, hours_q} + {5'd0, hr_c};
					hours_d = (hr_inc >= HOUR_MOD) ? 5'd0 : hr_inc[4:0];
				end
				if (pressed) begin
					do_enter     = 1'b1;
					enter_target = MODE_HOUR_BLINK;
				end
			end
		endcase

		if (do_enter) begin
			mode_d  = enter_target;
			pt_d    = 8'd0;
			blink_d = 4'd0;
			hold_d  = 6'd0;
			steps_d = 8'd0;
			fast_d  = 1'b0;
		end

		view.hours   = hours_d;
		view.minutes = minutes_d;
		view.seconds = seconds_d;
		view.mode    = mode_d;
		view.fade    = fade;
		view.blank_h = 1'b0;
		view.blank_m = 1'b0;
		if ((mode_d == MODE_HOUR_BLINK || mode_d == MODE_MIN_BLINK
				|| mode_d == MODE_EXIT_BLINK) && pt_d >= {2'b00, cfg.blink_half}) begin
			view.blank_h = (mode_d != MODE_MIN_BLINK);
			view.blank_m = (mode_d != MODE_HOUR_BLINK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_q   <= HOURS_RST;
			minutes_q <= 6'd0;
			seconds_q <= 6'd0;
			presc_q   <= 6'd0;
			mode_q    <= MODE_CLOCK;
			pt_q      <= 8'd0;
			blink_q   <= 4'd0;
			hold_q    <= 6'd0;
			steps_q   <= 8'd0;
			fast_q    <= 1'b0;
		end else if (step) begin
			hours_q   <= hours_d;
			minutes_q <= minutes_d;
			seconds_q <= seconds_d;
			presc_q   <= presc_d;
			mode_q    <= mode_d;
			pt_q      <= pt_d;
			blink_q   <= blink_d;
			hold_q    <= hold_d;
			steps_q   <= steps_d;
			fast_q    <= fast_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/cbts_fmt.sv =====
`default_nettype none

module cbts_fmt
	import cbts_pkg::*;
(
	input  wire cbts_view_t       view,
	output logic [OUT_W-1:0]      tdata
);

	logic [5:0] hr6;
	logic [5:0] c_ht, c_ho, c_mt, c_mo;

	always_comb begin
		hr6  = {1'b0, view.hours};
		c_ht = view.blank_h ? CHAR_SPACE : CHAR_ZERO + {3'b000, digit_tens(hr6)};
		c_ho = view.blank_h ? CHAR_SPACE : CHAR_ZERO + {2'b00, digit_ones(hr6)};
		c_mt = view.blank_m ? CHAR_SPACE : CHAR_ZERO + {3'b000, digit_tens(view.minutes)};
		c_mo = view.blank_m ? CHAR_SPACE : CHAR_ZERO + {2'b00, digit_ones(view.minutes)};
		tdata = {3'b000, view.fade, c_mo, c_mt, c_ho, c_ht, view.mode,
			view.seconds, view.minutes, view.hours};
	end

endmodule

`default_nettype wire

// ===== src/clock_with_button_time_set.sv =====
// Channel | Dir | Handshake               | Payload
// s_      | in  | s_tvalid / s_tready     | s_tdata: button_held, button_pressed
// m_      | out | m_tvalid / m_tready     | m_tdata: time, mode, four digit chars, fade
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One result beat per input beat, held in the result register; a new beat is
// taken every cycle while the result register is empty or being drained.
// The clock and time update ahead of the result register is combinational.
// Reset: time 09:00:00, clock mode, config registers at their defaults.
// A stalled m_ side holds the result and s_tready stays low until it is taken.
// cfg_ready is always high.
`default_nettype none

module clock_with_button_time_set
	import cbts_pkg::*;
#(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_W-1:0]       s_tdata,   // [0] button_held, [1] button_pressed
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [4:0] hour_value, [10:5] minute_value, [16:11] second_value, [19:17] ui_mode,
	// [25:20] char_hours_tens, [31:26] char_hours_ones, [37:32] char_minutes_tens,
	// [43:38] char_minutes_ones, [44] fade_request
	output logic [OUT_W-1:0]           m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cbts_cfg_t          cfg_q;
	cbts_view_t         view;
	logic [OUT_W-1:0]   res_data;
	logic               step;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign step      = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_rate    <= SLOW_RATE_RST;
			cfg_q.fast_rate    <= FAST_RATE_RST;
			cfg_q.fast_after   <= FAST_AFTER_RST;
			cfg_q.idle_timeout <= IDLE_TIMEOUT_RST;
			cfg_q.blink_reps   <= BLINK_REPS_RST;
			cfg_q.blink_half   <= BLINK_HALF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SLOW_RATE:    cfg_q.slow_rate    <= cfg_data[5:0];
				CFG_FAST_RATE:    cfg_q.fast_rate    <= cfg_data[5:0];
				CFG_FAST_AFTER:   cfg_q.fast_after   <= cfg_data;
				CFG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data;
				CFG_BLINK_REPS:   cfg_q.blink_reps   <= cfg_data[3:0];
				CFG_BLINK_HALF:   cfg_q.blink_half   <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	cbts_core #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.held    (s_tdata[0]),
		.pressed (s_tdata[1]),
		.cfg     (cfg_q),
		.view    (view)
	);

	cbts_fmt u_fmt (
		.view  (view),
		.tdata (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= res_data;
		end
	end

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid)
		else $error("accepted beat produced no result");

	a_clock_not_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19:17] == MODE_CLOCK |->
			m_tdata[25:20] != CHAR_SPACE && m_tdata[37:32] != CHAR_SPACE)
		else $error("digits blanked in clock mode");

	// a press on the rollover tick shows the fade with hour blink already entered
	a_fade_in_clock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[44] |->
			(m_tdata[19:17] == MODE_CLOCK || m_tdata[19:17] == MODE_HOUR_BLINK)
			&& m_tdata[16:11] == 6'd0)
		else $error("fade outside a clock-mode rollover");

	a_set_not_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[19:17] == MODE_SET_HOURS || m_tdata[19:17] == MODE_SET_MINS) |->
			m_tdata[31:26] != CHAR_SPACE && m_tdata[43:38] != CHAR_SPACE)
		else $error("digits blanked in a set phase");

endmodule

`default_nettype wire

// ===== dv/tb_clock_with_button_time_set.sv =====
`timescale 1ns / 100ps

module tb_clock_with_button_time_set;
	import cbts_pkg::*;

	typedef struct {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] mode;
		logic [5:0] hours_tens;
		logic [5:0] hours_ones;
		logic [5:0] minutes_tens;
		logic [5:0] minutes_ones;
		logic       fade;
	} face_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	clock_with_button_time_set dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock model state
	logic [4:0] hrs = HOURS_RST;
	logic [5:0] mins = '0;
	logic [5:0] secs = '0;
	logic [5:0] presc = '0;
	cbts_mode_t mode = MODE_CLOCK;
	logic [7:0] ptimer = '0;
	logic [3:0] blinks = '0;
	logic [5:0] hold_cnt = '0;
	logic [7:0] hold_steps = '0;
	logic       fast_on = 1'b0;

	// register copies
	logic [5:0] slow_rate = SLOW_RATE_RST;
	logic [5:0] fast_rate = FAST_RATE_RST;
	logic [7:0] fast_after = FAST_AFTER_RST;
	logic [7:0] idle_limit = IDLE_TIMEOUT_RST;
	logic [3:0] blink_reps = BLINK_REPS_RST;
	logic [5:0] blink_half = BLINK_HALF_RST;

	face_t face_q[$];
	face_t face_got;
	int    errors = 0;
	int    gap_pct = 0;
	int    stall_pct = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_clock_with_button_time_set: done, errors");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (face_q.size() == 0) begin
				$error("result beat with no expectation pending");
				errors++;
			end else begin
				face_got = face_q.pop_front();
				check_field("hour_value", face_got.hour, m_tdata[4:0]);
				check_field("minute_value", face_got.minute, m_tdata[10:5]);
				check_field("second_value", face_got.second, m_tdata[16:11]);
				check_field("ui_mode", face_got.mode, m_tdata[19:17]);
				check_field("char_hours_tens", face_got.hours_tens, m_tdata[25:20]);
				check_field("char_hours_ones", face_got.hours_ones, m_tdata[31:26]);
				check_field("char_minutes_tens", face_got.minutes_tens, m_tdata[37:32]);
				check_field("char_minutes_ones", face_got.minutes_ones, m_tdata[43:38]);
				check_field("fade_request", face_got.fade, m_tdata[44]);
				check_field("tdata_pad", 0, m_tdata[OUT_W-1:45]);
			end
		end
	end

	task automatic enter_mode(input cbts_mode_t m);
		mode = m;
		ptimer = '0;
		blinks = '0;
		hold_cnt = '0;
		hold_steps = '0;
		fast_on = 1'b0;
	endtask

	task automatic bump_setting();
		if (mode == MODE_SET_HOURS)
			hrs = (hrs == 5'd23) ? 5'd0 : hrs + 5'd1;
		else
			mins = (mins == 6'd59) ? 6'd0 : mins + 6'd1;
		if (hold_steps != 8'hFF)
			hold_steps++;
	endtask

	task automatic advance_display(input bit held, input bit pressed);
		bit         due;
		bit         fade;
		bit         blank_h;
		bit         blank_m;
		cbts_mode_t nxt;
		int         target;
		face_t      f;
		due = 1'b0;
		fade = 1'b0;
		if (presc == 6'd63) begin
			presc = '0;
			due = 1'b1;
		end else begin
			presc++;
		end
		case (mode)
			MODE_HOUR_BLINK, MODE_MIN_BLINK, MODE_EXIT_BLINK: begin
				nxt = (mode == MODE_EXIT_BLINK) ? MODE_CLOCK : cbts_mode_t'(mode + 3'd1);
				if (blinks >= blink_reps) begin
					if (nxt == MODE_CLOCK) secs = '0;
					enter_mode(nxt);
				end else begin
					ptimer++;
					if (ptimer >= {1'b0, blink_half, 1'b0}) begin
						ptimer = '0;
						blinks++;
						if (blinks >= blink_reps) begin
							if (nxt == MODE_CLOCK) secs = '0;
							enter_mode(nxt);
						end
					end
				end
			end
			MODE_SET_HOURS, MODE_SET_MINS: begin
				if (held) begin
					target = 64 - int'(fast_on ? fast_rate : slow_rate);
					ptimer = '0;
					if (hold_cnt == '0) begin
						hold_cnt = 6'd1;
						bump_setting();
					end else if (int'(hold_cnt) == target) begin
						hold_cnt = 6'd1;
						bump_setting();
						if (hold_steps == fast_after) fast_on = 1'b1;
					end else begin
						hold_cnt++;
					end
				end else begin
					hold_cnt = '0;
					hold_steps = '0;
					fast_on = 1'b0;
					if (ptimer != 8'hFF) ptimer++;
					if (ptimer >= idle_limit) enter_mode(cbts_mode_t'(mode + 3'd1));
				end
			end
			default: begin
				mode = MODE_CLOCK;
				if (due) begin
					if (secs == 6'd59) begin
						secs = '0;
						fade = 1'b1;
						if (mins == 6'd59) begin
							mins = '0;
							hrs = (hrs == 5'd23) ? 5'd0 : hrs + 5'd1;
						end else begin
							mins++;
						end
					end else begin
						secs++;
					end
				end
				if (pressed) enter_mode(MODE_HOUR_BLINK);
			end
		endcase
		blank_h = 1'b0;
		blank_m = 1'b0;
		if ((mode == MODE_HOUR_BLINK || mode == MODE_MIN_BLINK || mode == MODE_EXIT_BLINK)
				&& ptimer >= {2'b00, blink_half}) begin
			blank_h = (mode != MODE_MIN_BLINK);
			blank_m = (mode != MODE_HOUR_BLINK);
		end
		f.hour = hrs;
		f.minute = mins;
		f.second = secs;
		f.mode = mode;
		f.hours_tens = blank_h ? CHAR_SPACE : CHAR_ZERO + 6'(hrs / 5'd10);
		f.hours_ones = blank_h ? CHAR_SPACE : CHAR_ZERO + 6'(hrs % 5'd10);
		f.minutes_tens = blank_m ? CHAR_SPACE : CHAR_ZERO + (mins / 6'd10);
		f.minutes_ones = blank_m ? CHAR_SPACE : CHAR_ZERO + (mins % 6'd10);
		f.fade = fade;
		face_q.push_back(f);
	endtask

	task automatic send_tick(input bit held, input bit pressed);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = {{(IN_W-2){1'b0}}, pressed, held};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		advance_display(held, pressed);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (face_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SLOW_RATE:    slow_rate = val[5:0];
			CFG_FAST_RATE:    fast_rate = val[5:0];
			CFG_FAST_AFTER:   fast_after = val;
			CFG_IDLE_TIMEOUT: idle_limit = val;
			CFG_BLINK_REPS:   blink_reps = val[3:0];
			CFG_BLINK_HALF:   blink_half = val[5:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(input int slow, input int fast, input int after, input int timeout,
			input int reps, input int half);
		wait_drained();
		write_reg(CFG_SLOW_RATE, 8'(slow));
		write_reg(CFG_FAST_RATE, 8'(fast));
		write_reg(CFG_FAST_AFTER, 8'(after));
		write_reg(CFG_IDLE_TIMEOUT, 8'(timeout));
		write_reg(CFG_BLINK_REPS, 8'(reps));
		write_reg(CFG_BLINK_HALF, 8'(half));
	endtask

	task automatic test_reset_view();
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
	endtask

	// default blink timing, presses ignored outside clock mode
	task automatic test_press_blink();
		send_tick(1'b1, 1'b1);
		repeat (4) send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		write_all(63, 63, 1, 1, 0, 1);
		while (mode != MODE_CLOCK) send_tick(1'b0, 1'b0);
	endtask

	// slow period 2; threshold of one never switches to fast
	task automatic test_quick_set();
		write_all(62, 63, 1, 1, 0, 1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		repeat (5) send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
	endtask

	// fast repeat kicks in; zero idle timeout and zero half period
	task automatic test_fast_repeat();
		write_all(60, 63, 2, 0, 0, 0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		repeat (12) send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		repeat (4) send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		write_all(0, 0, 255, 255, 15, 63);
		send_tick(1'b0, 1'b0);
	endtask

	// set 23:59 then let a few seconds pass in clock mode
	task automatic test_rollover();
		bit started;
		gap_pct = 0;
		stall_pct = 0;
		write_all(63, 63, 1, 1, 0, 1);
		started = 1'b0;
		while (!(started && mode == MODE_CLOCK)) begin
			if (mode == MODE_CLOCK) started = 1'b1;
			send_tick((mode == MODE_SET_HOURS && hrs != 5'd23) ||
				(mode == MODE_SET_MINS && mins != 6'd59), mode == MODE_CLOCK);
		end
		repeat (4 * 64 + 8) send_tick(1'b0, 1'b0);
	endtask

	task automatic random_ticks(input int n);
		int run_left;
		bit run_held;
		bit held;
		bit pressed;
		run_left = 0;
		run_held = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (mode == MODE_SET_HOURS || mode == MODE_SET_MINS) begin
				if (run_left == 0) begin
					run_held = ($urandom_range(0, 99) < 55);
					if (run_held)
						run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 150)
							: $urandom_range(1, 12);
					else
						run_left = $urandom_range(1, int'(idle_limit) + 3);
				end
				run_left--;
				held = run_held;
				pressed = ($urandom_range(0, 7) == 0);
			end else if (mode == MODE_CLOCK) begin
				run_left = 0;
				held = 1'($urandom);
				pressed = ($urandom_range(0, 19) == 0);
			end else begin
				held = 1'($urandom);
				pressed = 1'($urandom);
			end
			send_tick(held, pressed);
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: write_all(1, 1, 1, 1, 0, 1);
				1: write_all(63, 63, 255, 255, 1, 63);
				2: write_all(0, 0, 3, 0, 15, 1);
				3: write_all(int'(SLOW_RATE_RST), int'(FAST_RATE_RST), int'(FAST_AFTER_RST),
					40, int'(BLINK_REPS_RST), int'(BLINK_HALF_RST));
				default: write_all($urandom_range(44, 63), $urandom_range(56, 63),
					$urandom_range(1, 6), $urandom_range(0, 24), $urandom_range(0, 3),
					$urandom_range(0, 5));
			endcase
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 50; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 50; end
				default: begin gap_pct = 32; stall_pct = 32; end
			endcase
			random_ticks(195);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_view();
		test_press_blink();
		test_quick_set();
		gap_pct = 32;
		stall_pct = 32;
		test_fast_repeat();
		test_rollover();
		test_random_phases();
		wait_drained();
		if (errors == 0)
			$display("tb_clock_with_button_time_set: done, clean");
		else
			$display("tb_clock_with_button_time_set: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cbts_pkg.sv
src/cbts_core.sv
src/cbts_fmt.sv
src/clock_with_button_time_set.sv
dv/tb_clock_with_button_time_set.sv
